[hw/rtl/mrrd_pkg.sv]
package mrrd_pkg;

   localparam int unsigned RX_SIZE_DEF       = 256;
   localparam int unsigned SUBSCRIPTIONS_DEF = 4;
   localparam int unsigned SUB_MAX           = 4;

   localparam logic [8:0]  MIN_FRAME   = 9'd8;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [15:0] COIL_ON     = 16'hFF00;
   localparam logic [15:0] MAX_BITS_RD = 16'd2000;
   localparam logic [15:0] MAX_REGS_RD = 16'd125;
   localparam logic [15:0] MAX_BITS_WR = 16'd1968;
   localparam logic [15:0] MAX_REGS_WR = 16'd123;

   localparam logic [2:0] REG_SLAVE_ADDR = 3'd0;
   localparam logic [2:0] REG_BROADCAST  = 3'd1;
   localparam logic [2:0] REG_SUB_BASE   = 3'd2;

   localparam logic [1:0] EXC_NONE     = 2'd0;
   localparam logic [1:0] EXC_FUNCTION = 2'd1;
   localparam logic [1:0] EXC_VALUE    = 2'd2;
   localparam logic [1:0] EXC_ADDRESS  = 2'd3;

   localparam logic [7:0] FC_READ_COILS  = 8'd1;
   localparam logic [7:0] FC_READ_DISC   = 8'd2;
   localparam logic [7:0] FC_READ_HOLD   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT  = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
   localparam logic [7:0] FC_WRITE_REG   = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

   typedef struct packed {
      logic [4:0]  function_code;
      logic [8:0]  frame_length;
      logic [15:0] start_address;
      logic [15:0] quantity_or_value;
      logic [15:0] span_end;
      logic [1:0]  exception_kind;
      logic [3:0]  subscriber_mask;
      logic        is_broadcast;
      logic        reply_needed;
      logic        last_of_run;
   } desc_type;

endpackage

[hw/rtl/modbus_rtu_request_deframer.sv]
// Modbus RTU request deframer. Bytes from the serial line are taken one per req_ transaction
// into a circular receive store of RX_SIZE bytes; after each byte the store is rescanned from
// its front, one stored byte per clock through a single RAM read port with the CRC-16 folded in
// byte by byte. req_ready is low for the whole rescan. Each good frame gives one rsp_
// transaction; the last one of a byte carries rsp_last_of_run. Registers are to be written
// through csr_ only while the block is idle; the block itself does not enforce this.
module modbus_rtu_request_deframer #(
   parameter int unsigned RX_SIZE       = mrrd_pkg::RX_SIZE_DEF,
   parameter int unsigned SUBSCRIPTIONS = mrrd_pkg::SUBSCRIPTIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_function_code,
   output logic [8:0]  rsp_frame_length,
   output logic [15:0] rsp_start_address,
   output logic [15:0] rsp_quantity_or_value,
   output logic [15:0] rsp_span_end,
   output logic [1:0]  rsp_exception_kind,
   output logic [3:0]  rsp_subscriber_mask,
   output logic        rsp_is_broadcast,
   output logic        rsp_reply_needed,
   output logic        rsp_last_of_run,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [39:0] csr_wdata
);
   import mrrd_pkg::*;

   localparam int unsigned AW = $clog2(RX_SIZE);
   localparam int unsigned FW = $clog2(RX_SIZE + 1);
   localparam logic [9:0]  SIZE10 = 10'(RX_SIZE);
   localparam logic [FW-1:0] SIZE_F = FW'(RX_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_STREAM, ST_DESC, ST_PLACE, ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       slave_ff, slave_in;
   logic             bcast_ff, bcast_in;
   logic [39:0]      sub_ff [SUBSCRIPTIONS];
   logic [39:0]      sub_in [SUBSCRIPTIONS];
   logic [AW-1:0]    head_ff, head_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [8:0]       iss_ff, iss_in;
   logic [8:0]       ridx_ff, ridx_in;
   logic             rvld_ff, rvld_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crclo_ff, crclo_in;
   logic [8:0]       flen_ff, flen_in;
   logic [7:0]       b0_ff, b0_in, code_ff, code_in, b6_ff, b6_in;
   logic [15:0]      addr_ff, addr_in, qty_ff, qty_in;
   desc_type         cand_ff, cand_in, pend_ff, pend_in, out_ff, out_in;
   logic             pvld_ff, pvld_in, ovld_ff, ovld_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [7:0]       rd_data;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [9:0] off);
      logic [10:0] sum;
      sum = 11'(base) + 11'(off);
      if (sum >= 11'(RX_SIZE)) begin
         sum = sum - 11'(RX_SIZE);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   mrrd_ram #(.WIDTH(8), .DEPTH(RX_SIZE)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign wr_en     = req_valid && req_ready && (fill_ff < SIZE_F);
   assign wr_addr   = wrap_add(head_ff, 10'(fill_ff));
   assign rd_addr   = wrap_add(head_ff, {1'b0, iss_ff});

   // descriptor of the frame held in the capture registers
   logic        supported, vbad;
   logic [15:0] hi, qp7;
   logic [3:0]  mask;
   desc_type    d;

   always_comb begin
      hi        = addr_ff;
      if (code_ff != FC_WRITE_COIL && code_ff != FC_WRITE_REG && qty_ff != 16'd0) begin
         hi = addr_ff + qty_ff - 16'd1;
      end
      supported = 1'b0;
      mask      = '0;
      for (int i = 0; i < SUBSCRIPTIONS; i++) begin
         if (sub_ff[i][39:32] == code_ff) begin
            supported = 1'b1;
            if (addr_ff >= sub_ff[i][31:16] && hi <= sub_ff[i][15:0]) begin
               mask[i] = 1'b1;
            end
         end
      end
      qp7 = qty_ff + 16'd7;
      case (code_ff)
         FC_READ_COILS, FC_READ_DISC:
            vbad = (qty_ff == 16'd0) || (qty_ff > MAX_BITS_RD);
         FC_READ_HOLD, FC_READ_INPUT:
            vbad = (qty_ff == 16'd0) || (qty_ff > MAX_REGS_RD);
         FC_WRITE_COILS:
            vbad = (qty_ff == 16'd0) || (qty_ff > MAX_BITS_WR) || (b6_ff != qp7[10:3]);
         FC_WRITE_REGS:
            vbad = (qty_ff == 16'd0) || (qty_ff > MAX_REGS_WR)
                   || (b6_ff != {qty_ff[6:0], 1'b0});
         FC_WRITE_COIL:
            vbad = (qty_ff != 16'd0) && (qty_ff != COIL_ON);
         default:
            vbad = 1'b0;
      endcase
      d.function_code     = code_ff[4:0];
      d.frame_length      = flen_ff;
      d.start_address     = addr_ff;
      d.quantity_or_value = qty_ff;
      d.span_end          = hi;
      d.is_broadcast      = (b0_ff == 8'd0);
      d.last_of_run       = 1'b0;
      if (!supported) begin
         d.exception_kind  = EXC_FUNCTION;
         d.subscriber_mask = '0;
      end else if (vbad) begin
         d.exception_kind  = EXC_VALUE;
         d.subscriber_mask = '0;
      end else begin
         d.exception_kind  = (mask == '0) ? EXC_ADDRESS : EXC_NONE;
         d.subscriber_mask = mask;
      end
      d.reply_needed = (d.exception_kind != EXC_NONE) && !d.is_broadcast;
   end

   // scan sequencer
   logic [8:0]  flen_cur;
   logic        drop, out_free;
   logic [9:0]  head_sum;

   always_comb begin
      state_in = state_ff;
      slave_in = slave_ff;
      bcast_in = bcast_ff;
      for (int i = 0; i < SUBSCRIPTIONS; i++) begin
         sub_in[i] = sub_ff[i];
      end
      head_in  = head_ff;
      fill_in  = fill_ff;
      iss_in   = iss_ff;
      ridx_in  = ridx_ff;
      rvld_in  = 1'b0;
      crc_in   = crc_ff;
      crclo_in = crclo_ff;
      flen_in  = flen_ff;
      b0_in    = b0_ff;
      code_in  = code_ff;
      b6_in    = b6_ff;
      addr_in  = addr_ff;
      qty_in   = qty_ff;
      cand_in  = cand_ff;
      pend_in  = pend_ff;
      out_in   = out_ff;
      pvld_in  = pvld_ff;
      ovld_in  = ovld_ff && !rsp_ready;
      out_free = !ovld_ff || rsp_ready;
      drop     = 1'b0;
      flen_cur = flen_ff;
      head_sum = '0;

      if (csr_we) begin
         if (csr_index == REG_SLAVE_ADDR) begin
            slave_in = csr_wdata[7:0];
         end else if (csr_index == REG_BROADCAST) begin
            bcast_in = csr_wdata[0];
         end else begin
            for (int i = 0; i < SUBSCRIPTIONS; i++) begin
               if (csr_index == REG_SUB_BASE + 3'(i)) begin
                  sub_in[i] = csr_wdata;
               end
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (fill_ff < SIZE_F) begin
                  fill_in = fill_ff + FW'(1);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            iss_in = '0;
            crc_in = CRC_INIT;
            if (9'(fill_ff) < MIN_FRAME) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            iss_in  = iss_ff + 9'd1;
            ridx_in = iss_ff;
            rvld_in = 1'b1;
            if (rvld_ff) begin
               if (ridx_ff == 9'd6 && (code_ff == FC_WRITE_COILS || code_ff == FC_WRITE_REGS)) begin
                  flen_cur = 9'(rd_data) + 9'd9;
               end
               if (ridx_ff < 9'd6 || ridx_ff < flen_cur - 9'd2) begin
                  crc_in = crc_byte(crc_ff, rd_data);
               end
               case (ridx_ff)
                  9'd0: begin
                     b0_in = rd_data;
                     drop  = (rd_data != slave_ff) && !(rd_data == 8'd0 && bcast_ff);
                  end
                  9'd1: begin
                     code_in = rd_data;
                     flen_in = MIN_FRAME;
                     drop    = !(rd_data == FC_READ_COILS || rd_data == FC_READ_DISC
                                 || rd_data == FC_READ_HOLD || rd_data == FC_READ_INPUT
                                 || rd_data == FC_WRITE_COIL || rd_data == FC_WRITE_REG
                                 || rd_data == FC_WRITE_COILS || rd_data == FC_WRITE_REGS);
                  end
                  9'd2: addr_in[15:8] = rd_data;
                  9'd3: addr_in[7:0]  = rd_data;
                  9'd4: qty_in[15:8]  = rd_data;
                  9'd5: qty_in[7:0]   = rd_data;
                  9'd6: begin
                     b6_in   = rd_data;
                     flen_in = flen_cur;
                     if ({1'b0, flen_cur} > SIZE10) begin
                        drop = 1'b1;
                     end else if (9'(fill_ff) < flen_cur) begin
                        rvld_in  = 1'b0;
                        state_in = ST_FINISH;
                     end
                  end
                  default: ;
               endcase
               if (!drop && state_in == ST_STREAM && ridx_ff >= 9'd6) begin
                  if (ridx_ff == flen_cur - 9'd2) begin
                     crclo_in = rd_data;
                  end else if (ridx_ff == flen_cur - 9'd1) begin
                     rvld_in = 1'b0;
                     if (crc_ff == {rd_data, crclo_ff}) begin
                        state_in = ST_DESC;
                     end else begin
                        drop = 1'b1;
                     end
                  end
               end
               if (drop) begin
                  head_in  = wrap_add(head_ff, 10'd1);
                  fill_in  = fill_ff - FW'(1);
                  rvld_in  = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_DESC: begin
            cand_in  = d;
            head_sum = {1'b0, flen_ff};
            head_in  = wrap_add(head_ff, head_sum);
            fill_in  = fill_ff - flen_ff[FW-1:0];
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            if (!pvld_ff) begin
               pend_in  = cand_ff;
               pvld_in  = 1'b1;
               state_in = ST_SCAN;
            end else if (out_free) begin
               out_in   = pend_ff;
               ovld_in  = 1'b1;
               pend_in  = cand_ff;
               state_in = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (!pvld_ff || out_free) begin
               if (pvld_ff) begin
                  out_in             = pend_ff;
                  out_in.last_of_run = 1'b1;
                  ovld_in            = 1'b1;
                  pvld_in            = 1'b0;
               end
               if (fill_ff == SIZE_F) begin
                  head_in = wrap_add(head_ff, 10'd1);
                  fill_in = fill_ff - FW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slave_ff <= 8'd1;
         bcast_ff <= 1'b0;
         for (int i = 0; i < SUBSCRIPTIONS; i++) begin
            sub_ff[i] <= '0;
         end
         head_ff  <= '0;
         fill_ff  <= '0;
         rvld_ff  <= 1'b0;
         pvld_ff  <= 1'b0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         slave_ff <= slave_in;
         bcast_ff <= bcast_in;
         for (int i = 0; i < SUBSCRIPTIONS; i++) begin
            sub_ff[i] <= sub_in[i];
         end
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         rvld_ff  <= rvld_in;
         pvld_ff  <= pvld_in;
         ovld_ff  <= ovld_in;
      end
      iss_ff   <= iss_in;
      ridx_ff  <= ridx_in;
      crc_ff   <= crc_in;
      crclo_ff <= crclo_in;
      flen_ff  <= flen_in;
      b0_ff    <= b0_in;
      code_ff  <= code_in;
      b6_ff    <= b6_in;
      addr_ff  <= addr_in;
      qty_ff   <= qty_in;
      cand_ff  <= cand_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign rsp_valid             = ovld_ff;
   assign rsp_function_code     = out_ff.function_code;
   assign rsp_frame_length      = out_ff.frame_length;
   assign rsp_start_address     = out_ff.start_address;
   assign rsp_quantity_or_value = out_ff.quantity_or_value;
   assign rsp_span_end          = out_ff.span_end;
   assign rsp_exception_kind    = out_ff.exception_kind;
   assign rsp_subscriber_mask   = out_ff.subscriber_mask;
   assign rsp_is_broadcast      = out_ff.is_broadcast;
   assign rsp_reply_needed      = out_ff.reply_needed;
   assign rsp_last_of_run       = out_ff.last_of_run;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= SIZE_F)
      else $error("receive store fill above capacity");

   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (fill_ff < SIZE_F && !pvld_ff))
      else $error("idle with full store or held transaction");

   a_reply_rule: assert property (@(posedge clock) disable iff (reset)
      ovld_ff |-> (out_ff.reply_needed
                   == (out_ff.exception_kind != EXC_NONE && !out_ff.is_broadcast)))
      else $error("reply flag inconsistent with exception");

   a_mask_rule: assert property (@(posedge clock) disable iff (reset)
      ovld_ff && (out_ff.exception_kind == EXC_FUNCTION || out_ff.exception_kind == EXC_VALUE)
      |-> out_ff.subscriber_mask == 4'd0)
      else $error("subscriber mask set on rejected request");

   a_drop_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STREAM && state_in == ST_SCAN |=> fill_ff == $past(fill_ff) - FW'(1))
      else $error("resync did not drop exactly one byte");

endmodule

[hw/rtl/mrrd_ram.sv]
module mrrd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/tb_modbus_rtu_request_deframer.sv]
module tb_modbus_rtu_request_deframer;
   timeunit 1ns;
   timeprecision 1ps;
   import mrrd_pkg::*;

   localparam int RXS = 256;
   localparam int WATCHDOG_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_function_code;
   logic [8:0]  rsp_frame_length;
   logic [15:0] rsp_start_address;
   logic [15:0] rsp_quantity_or_value;
   logic [15:0] rsp_span_end;
   logic [1:0]  rsp_exception_kind;
   logic [3:0]  rsp_subscriber_mask;
   logic        rsp_is_broadcast;
   logic        rsp_reply_needed;
   logic        rsp_last_of_run;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [39:0] csr_wdata = '0;

   modbus_rtu_request_deframer uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [7:0]  rx_store [RXS];
   int unsigned rx_fill;
   logic [7:0]  own_addr;
   logic        bc_ok;
   logic [39:0] subs [4];

   desc_type    frames_due [$];
   desc_type    typed_due [$];
   int          errors = 0;
   int          frames_seen = 0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   function automatic logic [15:0] crc16(int unsigned base, int unsigned n);
      logic [15:0] c;
      c = CRC_INIT;
      for (int unsigned i = 0; i < n; i++) begin
         c ^= {8'h00, rx_store[base + i]};
         for (int b = 0; b < 8; b++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic desc_type decode_frame(int unsigned p, int unsigned flen);
      desc_type    d;
      logic [7:0]  fc;
      logic [15:0] a, q, hi;
      logic [3:0]  mask;
      logic [1:0]  kind;
      logic        known, bad;
      int unsigned qi;
      fc = rx_store[p + 1];
      a = {rx_store[p + 2], rx_store[p + 3]};
      q = {rx_store[p + 4], rx_store[p + 5]};
      qi = q;
      hi = a;
      if (fc != FC_WRITE_COIL && fc != FC_WRITE_REG && q != 0) hi = a + q - 16'd1;
      known = 1'b0;
      mask = '0;
      for (int i = 0; i < 4; i++) if (subs[i][39:32] == fc) known = 1'b1;
      case (fc)
         FC_READ_COILS, FC_READ_DISC: bad = q < 1 || q > MAX_BITS_RD;
         FC_READ_HOLD, FC_READ_INPUT: bad = q < 1 || q > MAX_REGS_RD;
         FC_WRITE_COILS: bad = q < 1 || q > MAX_BITS_WR ||
                               rx_store[p + 6] != 8'((qi + 7) / 8);
         FC_WRITE_REGS: bad = q < 1 || q > MAX_REGS_WR || rx_store[p + 6] != 8'(qi * 2);
         FC_WRITE_COIL: bad = q != 16'h0000 && q != COIL_ON;
         default: bad = 1'b0;
      endcase
      if (!known) kind = EXC_FUNCTION;
      else if (bad) kind = EXC_VALUE;
      else begin
         for (int i = 0; i < 4; i++)
            if (subs[i][39:32] == fc && a >= subs[i][31:16] && hi <= subs[i][15:0])
               mask[i] = 1'b1;
         kind = (mask == 0) ? EXC_ADDRESS : EXC_NONE;
      end
      d.function_code = fc[4:0];
      d.frame_length = 9'(flen);
      d.start_address = a;
      d.quantity_or_value = q;
      d.span_end = hi;
      d.exception_kind = kind;
      d.subscriber_mask = mask;
      d.is_broadcast = rx_store[p] == 0;
      d.reply_needed = kind != EXC_NONE && rx_store[p] != 0;
      d.last_of_run = 1'b0;
      return d;
   endfunction

   task automatic predict_byte(input logic [7:0] b);
      int unsigned front, flen;
      int          found;
      logic [7:0]  fc;
      logic [15:0] c;
      found = 0;
      front = 0;
      if (rx_fill < RXS) begin
         rx_store[rx_fill] = b;
         rx_fill++;
      end
      while (rx_fill - front >= 8 && found < 32) begin
         if (rx_store[front] != own_addr && !(rx_store[front] == 0 && bc_ok)) begin
            front++;
            continue;
         end
         fc = rx_store[front + 1];
         case (fc)
            FC_READ_COILS, FC_READ_DISC, FC_READ_HOLD, FC_READ_INPUT,
            FC_WRITE_COIL, FC_WRITE_REG: flen = 8;
            FC_WRITE_COILS, FC_WRITE_REGS: flen = rx_store[front + 6] + 9;
            default: flen = 0;
         endcase
         if (flen == 0 || flen > RXS) begin
            front++;
            continue;
         end
         if (rx_fill - front < flen) break;
         c = crc16(front, flen - 2);
         if (c != {rx_store[front + flen - 1], rx_store[front + flen - 2]}) begin
            front++;
            continue;
         end
         frames_due.push_back(decode_frame(front, flen));
         found++;
         front += flen;
      end
      if (found > 0) frames_due[$].last_of_run = 1'b1;
      for (int unsigned i = front; i < rx_fill; i++) rx_store[i - front] = rx_store[i];
      rx_fill -= front;
      if (rx_fill == RXS) begin
         for (int unsigned i = 1; i < RXS; i++) rx_store[i - 1] = rx_store[i];
         rx_fill--;
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b);
      bytes_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SLAVE_ADDR: own_addr = val[7:0];
         REG_BROADCAST: bc_ok = val[0];
         default: if (idx >= REG_SUB_BASE && idx <= REG_SUB_BASE + 3)
            subs[idx - REG_SUB_BASE] = val;
      endcase
      @(negedge clock);
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      while ((frames_due.size() != 0 || !req_ready) && guard < WATCHDOG_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (600) @(negedge clock);
   endtask

   // frame builder: body bytes then CRC low, high
   task automatic send_frame(input logic [7:0] body [$]);
      logic [15:0] c;
      c = CRC_INIT;
      foreach (body[i]) begin
         c ^= {8'h00, body[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
      foreach (body[i]) send_byte(body[i]);
   endtask

   task automatic send_req(input logic [7:0] ad, input logic [7:0] fc,
                           input logic [15:0] a, input logic [15:0] q, input int nb,
                           input bit corrupt);
      logic [7:0] body [$];
      logic [7:0] cnt;
      body = '{ad, fc, a[15:8], a[7:0], q[15:8], q[7:0]};
      if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
         cnt = (nb >= 0) ? 8'(nb) : (fc == FC_WRITE_COILS ? 8'((int'(q) + 7) / 8) : 8'(q * 2));
         body.push_back(cnt);
         for (int i = 0; i < cnt; i++) body.push_back(8'($urandom));
      end
      if (corrupt) body[$urandom_range(body.size() - 1)] ^= 8'(1 << $urandom_range(7));
      send_frame(body);
   endtask

   always @(negedge clock) rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      desc_type got, want;
      if (!reset && (req_valid && req_ready || rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog expired", $realtime);
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_function_code, rsp_frame_length, rsp_start_address,
                 rsp_quantity_or_value, rsp_span_end, rsp_exception_kind,
                 rsp_subscriber_mask, rsp_is_broadcast, rsp_reply_needed, rsp_last_of_run};
         frames_seen++;
         if (frames_due.size() == 0) begin
            errors++;
            $display("%0t unexpected transaction %h", $realtime, got);
         end else begin
            want = frames_due.pop_front();
            if (typed_due.size() != 0) begin
               if (typed_due[0] != want) begin
                  errors++;
                  $display("%0t typed %h predictor %h", $realtime, typed_due[0], want);
               end
               void'(typed_due.pop_front());
            end
            if (got != want) begin
               errors++;
               $display("%0t expected %h actual %h", $realtime, want, got);
            end
         end
      end
   end

   typedef struct {
      logic [7:0]  ad, fc;
      logic [15:0] a, q;
      int          nb;
      bit          corrupt;
      bit          typed;
      desc_type    d;
   } stim_row;

   stim_row dir [] = '{
      '{1, FC_READ_COILS, 16'd0, 16'd1, -1, 0, 1,
        '{5'd1, 9'd8, 16'd0, 16'd1, 16'd0, EXC_NONE, 4'b0001, 1'b0, 1'b0, 1'b1}},
      '{1, FC_READ_COILS, 16'd0, 16'd2001, -1, 0, 1,
        '{5'd1, 9'd8, 16'd0, 16'd2001, 16'd2000, EXC_VALUE, 4'b0, 1'b0, 1'b1, 1'b1}},
      '{1, FC_READ_COILS, 16'hFFFF, 16'd2000, -1, 0, 0, '0},
      '{1, FC_READ_DISC, 16'd100, 16'd0, -1, 0, 0, '0},
      '{1, FC_READ_HOLD, 16'd10, 16'd125, -1, 0, 0, '0},
      '{1, FC_READ_HOLD, 16'd10, 16'd126, -1, 0, 0, '0},
      '{1, FC_READ_INPUT, 16'hFFFF, 16'hFFFF, -1, 0, 0, '0},
      '{1, FC_WRITE_COIL, 16'd5, COIL_ON, -1, 0, 0, '0},
      '{1, FC_WRITE_COIL, 16'd5, 16'h1234, -1, 0, 0, '0},
      '{1, FC_WRITE_REG, 16'd7, 16'hABCD, -1, 0, 0, '0},
      '{1, FC_WRITE_COILS, 16'd0, 16'd1968, 2, 0, 0, '0},
      '{1, FC_WRITE_COILS, 16'd0, 16'd9, 1, 0, 0, '0},
      '{1, FC_WRITE_REGS, 16'd20, 16'd123, 6, 0, 0, '0},
      '{1, FC_WRITE_REGS, 16'd20, 16'd3, 5, 0, 0, '0},
      '{1, 8'd7, 16'd0, 16'd1, -1, 0, 0, '0},
      '{0, FC_READ_HOLD, 16'd1, 16'd1, -1, 0, 0, '0},
      '{9, FC_READ_HOLD, 16'd1, 16'd1, -1, 0, 0, '0},
      '{1, FC_READ_HOLD, 16'd1, 16'd1, -1, 1, 0, '0},
      '{1, FC_READ_DISC, 16'd50, 16'd3, -1, 0, 0, '0}
   };

   function automatic logic [7:0] rand_code();
      logic [7:0] codes [8] = '{FC_READ_COILS, FC_READ_DISC, FC_READ_HOLD, FC_READ_INPUT,
                                FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS};
      return ($urandom_range(9) == 0) ? 8'($urandom) : codes[$urandom_range(7)];
   endfunction

   task automatic random_phase(input int n);
      logic [15:0] q;
      logic [7:0]  fc, ad;
      int          r;
      int          start;
      start = bytes_sent;
      while (bytes_sent - start < n) begin
         r = $urandom_range(99);
         if (r < 12) begin
            send_byte(8'($urandom));
         end else begin
            fc = rand_code();
            ad = ($urandom_range(4) == 0) ? 8'(($urandom_range(2) == 0) ? 0 : $urandom)
                                         : own_addr;
            case ($urandom_range(3))
               0: q = 16'($urandom);
               1: q = (fc == FC_WRITE_COIL) ? COIL_ON : 16'($urandom_range(3));
               default: q = 16'($urandom_range(1, (fc >= FC_WRITE_COILS) ? 24 : 130));
            endcase
            if (fc == FC_WRITE_COILS && $urandom_range(3) == 0) q = 16'($urandom_range(1900, 1968));
            send_req(ad, fc, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(300)), q,
                     ($urandom_range(9) == 0) ? int'($urandom_range(255)) : -1,
                     $urandom_range(9) == 0);
         end
      end
   endtask

   initial begin
      own_addr = 8'd1;
      bc_ok = 1'b0;
      rx_fill = 0;
      foreach (subs[i]) subs[i] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(REG_SLAVE_ADDR, 40'd1);
      write_reg(REG_BROADCAST, 40'd1);
      write_reg(REG_SUB_BASE, {FC_READ_COILS, 16'd0, 16'hFFFF});
      write_reg(REG_SUB_BASE + 3'd1, {FC_READ_HOLD, 16'd0, 16'd100});
      write_reg(REG_SUB_BASE + 3'd2, {FC_WRITE_REGS, 16'd10, 16'd200});
      write_reg(REG_SUB_BASE + 3'd3, {FC_WRITE_COIL, 16'd0, 16'd5});
      foreach (dir[i]) begin
         if (dir[i].typed) typed_due.push_back(dir[i].d);
         send_req(dir[i].ad, dir[i].fc, dir[i].a, dir[i].q, dir[i].nb, dir[i].corrupt);
      end
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 80 : 0;
         recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 19 : 0;
         write_reg(REG_SLAVE_ADDR, (ph == 1) ? 40'd247 : (ph == 2) ? 40'd0 : 40'($urandom_range(2, 246)));
         write_reg(REG_BROADCAST, 40'(ph != 0));
         for (int s = 0; s < 4; s++) begin
            logic [15:0] lo;
            lo = 16'($urandom_range(200));
            write_reg(REG_SUB_BASE + 3'(s),
                      {(ph == 2 && s == 3) ? 8'd0 : rand_code(), lo,
                       ($urandom_range(3) == 0) ? 16'hFFFF : lo + 16'($urandom_range(400))});
         end
         write_reg(3'd7, 40'hFF_FFFF_FFFF);
         random_phase(45);
         drain();
      end
      $display("Sent %0d bytes over four register settings, %0d frames checked.",
               bytes_sent, frames_seen);
      if (errors == 0 && frames_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d errors, %0d transactions outstanding", errors, frames_due.size());
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
